### rtl/deq_pkg.sv
// Shared constants, codes, types and index helpers for the double-ended queue.
package deq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = $clog2(2 * DEPTH);
    localparam int WORD_W = 32;
    localparam int OCC_W  = 4;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_POP_FRONT  = 2'd1,
        OP_PUSH_FRONT = 2'd2,
        OP_POP_BACK   = 2'd3
    } deq_op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } deq_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } deq_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_read;
    } deq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pop_ok;
    } deq_stat_t;

    // Ring index base + offset, wrapped once modulo DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Ring index one step back, wrapping below zero
    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] res;
        if (base == '0)
        begin
            res = IDX_W'(DEPTH - 1);
        end
        else
        begin
            res = base - 1'b1;
        end
        return res;
    endfunction

endpackage

### rtl/double_ended_queue_unit.sv
// Top level of the bounded double-ended queue unit.
// Holds up to DEPTH (8) signed 32-bit words in a ring store addressed by a head
// index and a word count. Raise start with func and data_in while busy is low;
// the operation is taken on that edge. Its result appears on status, data_out
// and occupancy for exactly one cycle with done high and cannot be held off.
// A push or a failed pop goes from the execute state to the result state, a
// successful pop from execute through read to result, the read state set by the
// registered read port of the entry store; busy stays high from the cycle after
// the transfer through the done cycle, so a new item is taken in the cycle after
// done at the earliest, never while the last one is in flight. Pushing onto a
// full queue reports full, popping an empty one reports empty; neither changes
// the queue. No clearing pass is needed after reset.
module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               func,
    input  logic signed [WORD_W-1:0] data_in,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [WORD_W-1:0] data_out,
    output logic [OCC_W-1:0]         occupancy
);

    deq_cmd_t  cmd;
    deq_stat_t stat;

    deq_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    deq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .func      (func),
        .data_in   (data_in),
        .status    (status),
        .data_out  (data_out),
        .occupancy (occupancy)
    );

    // A transfer makes the block busy on the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    // The result strobe lasts one cycle and frees the block
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    // A full report leaves the queue at capacity with no word
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (occupancy == OCC_W'(DEPTH) && data_out == '0))
        else $error("full status with wrong occupancy");

    // An empty report leaves the queue empty with no word
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (occupancy == '0 && data_out == '0))
        else $error("empty status with wrong occupancy");

endmodule

### rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/deq_datapath.sv
// Datapath: ring pointers, entry store and result registers of the queue.
module deq_datapath
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  deq_cmd_t                 cmd,
    output deq_stat_t                stat,
    input  logic [1:0]               func,
    input  logic signed [WORD_W-1:0] data_in,
    output logic [1:0]               status,
    output logic signed [WORD_W-1:0] data_out,
    output logic [OCC_W-1:0]         occupancy
);

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    deq_op_t           op_reg;
    logic [WORD_W-1:0] word_reg;
    deq_status_t       status_reg, status_next;
    logic [WORD_W-1:0] data_reg;
    logic [OCC_W-1:0]  occ_reg;

    logic              is_push, full, empty;
    logic              ram_we;
    logic [IDX_W-1:0]  waddr, raddr;
    logic [WORD_W-1:0] rdata;

    assign is_push = (op_reg == OP_PUSH_BACK) || (op_reg == OP_PUSH_FRONT);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign stat.pop_ok = !is_push && !empty;

    // Decide the store access and pointer update for the held operation
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        ram_we      = 1'b0;
        waddr       = wrap_add(head_reg, count_reg);
        raddr       = head_reg;
        unique case (op_reg)
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ram_we     = cmd.exec;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_PUSH_FRONT:
            begin
                waddr = wrap_dec(head_reg);
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ram_we     = cmd.exec;
                    head_next  = wrap_dec(head_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    head_next  = wrap_add(head_reg, CNT_W'(1));
                    count_next = count_reg - 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                raddr = wrap_add(head_reg, count_reg - 1'b1);
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    // Advance ring pointers on execute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Hold the operation and load the result fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= deq_op_t'(func);
            word_reg <= data_in;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            data_reg   <= '0;
            occ_reg    <= OCC_W'(count_next);
        end
        else if (cmd.load_read)
        begin
            data_reg <= rdata;
        end
    end

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (word_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status    = status_reg;
    assign data_out  = data_reg;
    assign occupancy = occ_reg;

endmodule

### rtl/deq_controller.sv
// Controller: sequences capture, execute, store read and result strobe.
module deq_controller
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output deq_cmd_t  cmd,
    input  deq_stat_t stat
);

    deq_state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        busy          = 1'b1;
        done          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.pop_ok ? S_READ : S_RESP;
            end
            S_READ:
            begin
                cmd.load_read = 1'b1;
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
